/* rtl/core/ycs_pkg.sv */
// Shared types, constants, the Yokoi evaluation function and the result-word builder for the connectivity stream.
package ycs_pkg;

   localparam int IMG_SIZE = 64;
   localparam int COL_W = $clog2(IMG_SIZE);
   localparam int ROW_W = $clog2(IMG_SIZE + 1);
   localparam int COORD_W = 6;
   localparam int CONN_W = 3;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   localparam logic [7:0] THRESH_RESET = 8'd128;
   localparam logic [CONN_W-1:0] CONN_INTERIOR = 3'd5;
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_PAD = 1'b1;

   // one column slot of the two line buffers
   typedef struct packed {
      logic mid;
      logic up;
   } line_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [CONN_W-1:0]  conn;
      logic               last;
      logic               done;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // window bit (k, j) sits at k*3+j, k = column left..right, j = row top..bottom
   function automatic logic [CONN_W-1:0] yokoi(input logic [8:0] w, input logic top,
                                               input logic bot, input logic lft,
                                               input logic rgt);
      logic x1, x2, x3, x4, x5, x6, x7, x8;
      logic [3:0] q;
      logic [3:0] r;
      logic [CONN_W-1:0] result;
      x1 = rgt & w[7];
      x2 = top & w[3];
      x3 = lft & w[1];
      x4 = bot & w[5];
      x5 = bot & rgt & w[8];
      x6 = top & rgt & w[6];
      x7 = top & lft & w[0];
      x8 = bot & lft & w[2];
      r[0] = x1 & x6 & x2;
      r[1] = x2 & x7 & x3;
      r[2] = x3 & x8 & x4;
      r[3] = x4 & x5 & x1;
      q[0] = x1 & ~r[0];
      q[1] = x2 & ~r[1];
      q[2] = x3 & ~r[2];
      q[3] = x4 & ~r[3];
      if (!w[4]) begin
         result = '0;
      end else if (&r) begin
         result = CONN_INTERIOR;
      end else begin
         result = CONN_W'({2'b00, q[0]} + {2'b00, q[1]} + {2'b00, q[2]} + {2'b00, q[3]});
      end
      return result;
   endfunction

   function automatic rsp_type make_rsp(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col,
                                        input logic [8:0] w, input logic last);
      rsp_type res;
      logic top, bot, lft, rgt;
      top = row != ROW_W'(0);
      bot = row != ROW_W'(IMG_SIZE - 1);
      lft = col != COL_W'(0);
      rgt = col != COL_W'(IMG_SIZE - 1);
      res.row = COORD_W'(row);
      res.col = COORD_W'(col);
      res.conn = yokoi(w, top, bot, lft, rgt);
      res.last = last;
      res.done = ~bot & ~rgt;
      return res;
   endfunction

endpackage

/* rtl/core/ycs_cell.sv */
// One column slot of the line-buffer ring: upper and middle row bits, shifted on each word.
module ycs_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  ycs_pkg::line_type  d_in,
   output ycs_pkg::line_type  q_out
);

   ycs_pkg::line_type slot_ff;
   ycs_pkg::line_type slot_in;

   assign slot_in = shift_en ? d_in : slot_ff;
   assign q_out = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

/* rtl/core/ycs_out_fifo.sv */
// Small result queue: takes up to two words per cycle, hands out one unless out_stall is high.
module ycs_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  ycs_pkg::push_type push,
   output logic              full_for_two,
   output logic              out_valid,
   input  logic              out_stall,
   output ycs_pkg::rsp_type  out_word
);

   ycs_pkg::rsp_type                   mem_ff [ycs_pkg::OUT_DEPTH];
   logic [ycs_pkg::OUT_PTR_W-1:0]      head_ff, head_in;
   logic [ycs_pkg::OUT_PTR_W-1:0]      tail_ff, tail_in;
   logic [ycs_pkg::OUT_PTR_W-1:0]      tail_next;
   logic [ycs_pkg::OUT_CNT_W-1:0]      count_ff, count_in;
   logic                               pop;

   assign out_valid = count_ff != '0;
   assign out_word = mem_ff[head_ff];
   assign pop = out_valid & ~out_stall;
   assign full_for_two = count_ff > ycs_pkg::OUT_CNT_W'(ycs_pkg::OUT_DEPTH - 2);
   assign tail_next = tail_ff + ycs_pkg::OUT_PTR_W'(1);

   always_comb begin
      head_in = pop ? head_ff + ycs_pkg::OUT_PTR_W'(1) : head_ff;
      tail_in = tail_ff + ycs_pkg::OUT_PTR_W'(push.count);
      count_in = count_ff + ycs_pkg::OUT_CNT_W'(push.count) - ycs_pkg::OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_next] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ycs_pkg::OUT_CNT_W'(ycs_pkg::OUT_DEPTH))
      else $error("result queue count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full_for_two |-> push.count == 2'd0)
      else $error("result queue written while full");

   a_pop_moves_head: assert property (@(posedge clock) disable iff (reset)
      pop |=> head_ff == $past(head_ff) + ycs_pkg::OUT_PTR_W'(1))
      else $error("head did not advance on pop");

endmodule

/* rtl/core/yokoi_connectivity_stream_unit.sv */
// Top level: threshold, line-buffer ring of cells, 3x3 window, Yokoi results and result queue.
// Ordering: a pixel's word is pushed when the input one row plus one pixel later is accepted
// (the image's last pixel goes with the last pad, one row later); with the queue empty
// it is presented straight from the queue's registers once that push is written.
// Throughput: one pixel per cycle unless req_stall is high; the last pad of an image pushes
// two words, absorbed by the four-entry result queue. req_stall is high only at three or more.
// Reset clears the line buffers, window and counters to background and sets threshold to 128.
module yokoi_connectivity_stream_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [7:0]                       csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [7:0]                       req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ycs_pkg::COORD_W-1:0]      rsp_row,
   output logic [ycs_pkg::COORD_W-1:0]      rsp_col,
   output logic [ycs_pkg::CONN_W-1:0]       rsp_connectivity,
   output logic                             rsp_last_in_run,
   output logic                             rsp_image_done
);

   logic [7:0]                   threshold_ff, threshold_in;
   logic [8:0]                   window_ff, window_in;
   logic [ycs_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [ycs_pkg::COL_W-1:0]    col_ff, col_in;
   logic                         accept;
   logic                         fg_bit;
   logic                         col_wrap;
   logic                         is_a, is_b, is_c;
   ycs_pkg::line_type            line_q [ycs_pkg::IMG_SIZE];
   ycs_pkg::line_type            ring_in;
   ycs_pkg::line_type            tail;
   ycs_pkg::rsp_type             res_a, res_b, res_c;
   ycs_pkg::push_type            push;
   ycs_pkg::rsp_type             out_word;

   assign accept = req_valid & ~req_stall;
   assign fg_bit = (req_op == ycs_pkg::OP_PIXEL) & (req_pixel >= threshold_ff);
   assign threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

   // ring of column slots; the tail holds the current column's two earlier rows
   assign tail = line_q[ycs_pkg::IMG_SIZE-1];
   assign ring_in.up = tail.mid;
   assign ring_in.mid = fg_bit;

   for (genvar i = 0; i < ycs_pkg::IMG_SIZE; i++) begin : g_ring
      if (i == 0) begin : g_head
         ycs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .d_in     (ring_in),
            .q_out    (line_q[i])
         );
      end else begin : g_body
         ycs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .d_in     (line_q[i-1]),
            .q_out    (line_q[i])
         );
      end
   end

   assign window_in = {fg_bit, tail.mid, tail.up, window_ff[8:3]};

   always_comb begin
      col_wrap = col_ff == ycs_pkg::COL_W'(ycs_pkg::IMG_SIZE - 1);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_ff == ycs_pkg::ROW_W'(ycs_pkg::IMG_SIZE)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ycs_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + ycs_pkg::COL_W'(1);
         end
      end
   end

   // previous row's last pixel, current window's center, and the image's final pixel
   always_comb begin
      is_a = (col_ff == '0) && (row_ff >= ycs_pkg::ROW_W'(2));
      is_b = (col_ff != '0) && (row_ff != '0);
      is_c = (row_ff == ycs_pkg::ROW_W'(ycs_pkg::IMG_SIZE)) && col_wrap;
      res_a = ycs_pkg::make_rsp(row_ff - ycs_pkg::ROW_W'(2),
                                ycs_pkg::COL_W'(ycs_pkg::IMG_SIZE - 1),
                                {3'b000, window_ff[8:3]}, 1'b1);
      res_b = ycs_pkg::make_rsp(row_ff - ycs_pkg::ROW_W'(1), col_ff - ycs_pkg::COL_W'(1),
                                window_in, ~is_c);
      res_c = ycs_pkg::make_rsp(ycs_pkg::ROW_W'(ycs_pkg::IMG_SIZE - 1),
                                ycs_pkg::COL_W'(ycs_pkg::IMG_SIZE - 1),
                                {3'b000, window_in[8:3]}, 1'b1);
      push.count = accept ? ({1'b0, is_a} + {1'b0, is_b} + {1'b0, is_c}) : 2'd0;
      push.first = is_a ? res_a : res_b;
      push.second = res_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ycs_pkg::THRESH_RESET;
         window_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
         window_ff <= accept ? window_in : window_ff;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   ycs_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full_for_two (req_stall),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_word     (out_word)
   );

   assign rsp_row = out_word.row;
   assign rsp_col = out_word.col;
   assign rsp_connectivity = out_word.conn;
   assign rsp_last_in_run = out_word.last;
   assign rsp_image_done = out_word.done;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_last_in_run)
      else $error("image end word not last of its run");

   a_two_only_at_end: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> row_ff == ycs_pkg::ROW_W'(ycs_pkg::IMG_SIZE) && col_wrap)
      else $error("double push away from the final pad");

   a_conn_range: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> push.first.conn <= ycs_pkg::CONN_INTERIOR)
      else $error("connectivity out of range");

endmodule
